/* rtl/wwl_pkg.sv */
`default_nettype none
package wwl_pkg;

  localparam int LINE_MAX_DEF   = 47;
  localparam int INDENT_MAX_DEF = 15;

  localparam int CHAR_W    = 8;
  localparam int COL_W     = 7;
  localparam int IND_W     = 4;
  localparam int WRAP_W    = 6;
  localparam int TS_W      = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [COL_W-1:0]  COL_TOP  = 7'd127;
  localparam logic [WRAP_W-1:0] WRAP_RST = 6'd40;
  localparam logic [TS_W-1:0]   TS_RST   = 5'd8;

  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_INDENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAB,
    S_IND,
    S_RD,
    S_BYTE,
    S_TAIL,
    S_APP
  } wwl_state_t;

  typedef enum logic [1:0] {
    K_FLUSH,
    K_BELL,
    K_WRAP
  } wwl_kind_t;

endpackage
`default_nettype wire

/* rtl/wwl_store.sv */
`default_nettype none
module wwl_store #(
  parameter int DEPTH = 47,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* rtl/wwl_tabdiv.sv */
`default_nettype none
module wwl_tabdiv (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [wwl_pkg::COL_W-1:0] num,
  input  wire logic [wwl_pkg::TS_W-1:0]  den,
  output logic                          done,
  output logic      [wwl_pkg::TS_W-1:0]  rem
);
  import wwl_pkg::*;

  localparam int CW = $clog2(COL_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [COL_W-1:0]  num_r, num_nxt;
  logic [TS_W-1:0]   den_r, den_nxt;
  logic [TS_W-1:0]   rem_r, rem_nxt;
  logic [TS_W:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, num_r[COL_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(COL_W);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = TS_W'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = trial[TS_W-1:0];
      end
      num_nxt = {num_r[COL_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

/* rtl/word_wrap_line_buffer.sv */
// Greedy word-wrap line buffer.
// in_*  : one text byte per word; taken only when the block is idle.
// out_* : emitted bytes; out_tlast marks the final byte caused by one input,
//         out_tuser carries the sticky tab overflow flag.
// cfg_* : register writes (0 indent, 1 wrap width, 2 tab stop), always ready;
//         write only while the block is idle.
// Steps per input word (each stored byte takes a registered line store read):
//   ordinary byte, no break: accept, then store; bell: emit it; tab: store,
//   then wait on the bit-serial remainder unit (one bit of the column per
//   cycle); tab on a full store: set the overflow flag; newline or carriage
//   return: indent, each stored byte, then the input byte; line break: indent,
//   each stored byte before the break, a newline, then store the input byte.
// A single output register parts the two sides; a stall on out_tready holds
// the current word and stalls the states that emit bytes until it is taken.
// Reset empties the line, clears the column and the overflow flag and loads
// indent 0, wrap width 40, tab stop 8; the line store itself needs no clear.
`default_nettype none
module word_wrap_line_buffer #(
  parameter int LINE_MAX   = wwl_pkg::LINE_MAX_DEF,
  parameter int INDENT_MAX = wwl_pkg::INDENT_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [wwl_pkg::CHAR_W-1:0]    in_tdata,   // [7:0] ch
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [wwl_pkg::CHAR_W-1:0]    out_tdata,  // [7:0] out_char
  output logic                               out_tlast,
  output logic                               out_tuser,  // [0] overflowed
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [wwl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wwl_pkg::WRAP_W-1:0]    cfg_data
);
  import wwl_pkg::*;

  localparam int IDX_W = $clog2(LINE_MAX);
  localparam int CNT_W = $clog2(LINE_MAX + 1);

  wwl_state_t        state_r, state_nxt;
  wwl_kind_t         kind_r, kind_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [IND_W-1:0]  ind_left_r, ind_left_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              ovf_r, ovf_nxt;
  logic              has_sep_r, has_sep_nxt;
  logic [IDX_W-1:0]  sep_r, sep_nxt;
  logic [IND_W-1:0]  indent_r;
  logic [WRAP_W-1:0] wrap_r;
  logic [TS_W-1:0]   ts_r;
  logic              ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0] odata_r, odata_nxt;
  logic              olast_r, olast_nxt;
  logic              ouser_r, ouser_nxt;

  logic              ob_free;
  logic [IND_W-1:0]  ind_eff;
  logic [WRAP_W-1:0] lim;
  logic [TS_W-1:0]   ts_eff;
  logic [IDX_W-1:0]  wr_pos;
  logic              full;
  logic [CNT_W-1:0]  sep_p1;
  logic [CNT_W-1:0]  fill_left;
  logic [COL_W:0]    tab_sum;

  logic              wr_en;
  logic [CHAR_W-1:0] wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic              div_start;
  logic              div_done;
  logic [TS_W-1:0]   div_rem;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(LINE_MAX)) begin
      s = s - (CNT_W+1)'(LINE_MAX);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  wwl_store #(
    .DEPTH (LINE_MAX),
    .AW    (IDX_W),
    .DW    (CHAR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_pos),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wwl_tabdiv u_tabdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (col_r),
    .den   (ts_eff),
    .done  (div_done),
    .rem   (div_rem)
  );

  assign ob_free   = !ovalid_r || out_tready;
  assign ind_eff   = (indent_r > IND_W'(INDENT_MAX)) ? IND_W'(INDENT_MAX) : indent_r;
  assign lim       = (wrap_r > WRAP_W'(LINE_MAX)) ? WRAP_W'(LINE_MAX) : wrap_r;
  assign ts_eff    = (ts_r == '0) ? TS_W'(1) : ts_r;
  assign wr_pos    = ring_add(head_r, fill_r);
  assign full      = fill_r >= CNT_W'(LINE_MAX);
  assign sep_p1    = CNT_W'(sep_r) + CNT_W'(1);
  assign fill_left = fill_r - sep_p1;
  assign tab_sum   = (COL_W+1)'(col_r) + (COL_W+1)'(ts_eff) - (COL_W+1)'(div_rem);
  assign rd_addr   = ring_add(head_r, idx_r);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = ouser_r;

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    ch_nxt       = ch_r;
    ind_left_nxt = ind_left_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    col_nxt      = col_r;
    ovf_nxt      = ovf_r;
    has_sep_nxt  = has_sep_r;
    sep_nxt      = sep_r;
    ovalid_nxt   = ovalid_r && !out_tready;
    odata_nxt    = odata_r;
    olast_nxt    = olast_r;
    ouser_nxt    = ouser_r;
    wr_en        = 1'b0;
    wr_data      = ch_r;
    rd_en        = 1'b0;
    div_start    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ch_nxt  = in_tdata;
          idx_nxt = '0;
          if ((in_tdata == CH_LF) || (in_tdata == CH_CR)) begin
            kind_nxt     = K_FLUSH;
            ind_left_nxt = ind_eff;
            len_nxt      = fill_r;
            state_nxt    = S_IND;
          end else if (in_tdata == CH_BEL) begin
            kind_nxt     = K_BELL;
            ind_left_nxt = '0;
            len_nxt      = '0;
            state_nxt    = S_IND;
          end else if (in_tdata == CH_TAB) begin
            if (full) begin
              ovf_nxt = 1'b1;
            end else begin
              wr_en       = 1'b1;
              wr_data     = in_tdata;
              fill_nxt    = fill_r + CNT_W'(1);
              has_sep_nxt = 1'b1;
              sep_nxt     = fill_r[IDX_W-1:0];
              div_start   = 1'b1;
              state_nxt   = S_TAB;
            end
          end else if (col_r >= COL_W'(lim)) begin
            kind_nxt     = K_WRAP;
            ind_left_nxt = ind_eff;
            len_nxt      = has_sep_r ? CNT_W'(sep_r) : fill_r;
            state_nxt    = S_IND;
          end else begin
            state_nxt = S_APP;
          end
        end
      end
      S_TAB: begin
        if (div_done) begin
          col_nxt   = (tab_sum > (COL_W+1)'(COL_TOP)) ? COL_TOP : tab_sum[COL_W-1:0];
          state_nxt = S_IDLE;
        end
      end
      S_IND: begin
        if (ind_left_r != '0) begin
          if (ob_free) begin
            ovalid_nxt   = 1'b1;
            odata_nxt    = CH_SP;
            olast_nxt    = 1'b0;
            ouser_nxt    = ovf_r;
            ind_left_nxt = ind_left_r - IND_W'(1);
          end
        end else begin
          state_nxt = (idx_r < len_r) ? S_RD : S_TAIL;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_BYTE;
      end
      S_BYTE: begin
        if (ob_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = rd_data;
          olast_nxt  = 1'b0;
          ouser_nxt  = ovf_r;
          idx_nxt    = idx_r + CNT_W'(1);
          state_nxt  = ((idx_r + CNT_W'(1)) < len_r) ? S_RD : S_TAIL;
        end
      end
      S_TAIL: begin
        if (ob_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = (kind_r == K_WRAP) ? CH_LF : ch_r;
          olast_nxt  = 1'b1;
          ouser_nxt  = ovf_r;
          case (kind_r)
            K_FLUSH: begin
              head_nxt    = '0;
              fill_nxt    = '0;
              col_nxt     = '0;
              has_sep_nxt = 1'b0;
              state_nxt   = S_IDLE;
            end
            K_WRAP: begin
              if (has_sep_r) begin
                head_nxt = ring_add(head_r, sep_p1);
                fill_nxt = fill_left;
                col_nxt  = COL_W'(fill_left);
              end else begin
                head_nxt = '0;
                fill_nxt = '0;
                col_nxt  = '0;
              end
              has_sep_nxt = 1'b0;
              state_nxt   = S_APP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_APP: begin
        if (!full) begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + CNT_W'(1);
          if (is_sep(ch_r)) begin
            has_sep_nxt = 1'b1;
            sep_nxt     = fill_r[IDX_W-1:0];
          end
        end
        col_nxt   = (col_r == COL_TOP) ? COL_TOP : col_r + COL_W'(1);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      fill_r    <= '0;
      col_r     <= '0;
      ovf_r     <= 1'b0;
      has_sep_r <= 1'b0;
      ovalid_r  <= 1'b0;
      indent_r  <= '0;
      wrap_r    <= WRAP_RST;
      ts_r      <= TS_RST;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      col_r     <= col_nxt;
      ovf_r     <= ovf_nxt;
      has_sep_r <= has_sep_nxt;
      ovalid_r  <= ovalid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_INDENT: indent_r <= cfg_data[IND_W-1:0];
          CFG_WRAP:   wrap_r   <= cfg_data[WRAP_W-1:0];
          CFG_TAB:    ts_r     <= cfg_data[TS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    ch_r       <= ch_nxt;
    ind_left_r <= ind_left_nxt;
    idx_r      <= idx_nxt;
    len_r      <= len_nxt;
    sep_r      <= sep_nxt;
    odata_r    <= odata_nxt;
    olast_r    <= olast_nxt;
    ouser_r    <= ouser_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(LINE_MAX))
    else $error("line store fill beyond capacity");

  a_col_covers_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (col_r >= COL_W'(fill_r)))
    else $error("column behind stored byte count");

  a_sep_inside: assert property (@(posedge clk) disable iff (!rst_n)
    has_sep_r |-> (CNT_W'(sep_r) < fill_r))
    else $error("break position outside stored line");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag dropped");

endmodule
`default_nettype wire
